[rtl/cfp_pkg.sv]
// Shared types and the CRC-16/ARC byte update for the command frame parser.
// No dependencies; imported by every module of the block except cfp_checker.
package cfp_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] CFG_HEAD_IDX = 8'd0;
    localparam logic [7:0] CFG_TAIL_IDX = 8'd1;

    localparam logic [7:0] HEAD_RESET = 8'hA5;
    localparam logic [7:0] TAIL_RESET = 8'h5A;

    // One accepted frame, handed from the parser to the result stage.
    typedef struct packed {
        logic [7:0]  cmd;
        logic [15:0] len;
        logic        fits;
        logic        has_payload;
        logic        bank;
    } t_desc;

    // Payload store write request from the parser.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] data;
    } t_wr;

    // Result stage releases a payload bank after its last byte is read.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_free;

    function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/cfp_front.sv]
// Frame parser: byte-per-cycle phase machine (unless o_full stalls it), CRC check, payload writes.
// Depends on cfp_pkg.
module cfp_front #(
    parameter int unsigned PAYLOAD_CAPACITY = 64,
    localparam int unsigned IDX_W = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [7:0]               i_data_byte,
    output logic                     o_full,
    input  logic [7:0]               i_head_byte,
    input  logic [7:0]               i_tail_byte,
    output cfp_pkg::t_wr             o_wr,
    output logic [IDX_W-1:0]         o_wr_idx,
    output logic                     o_desc_push,
    output cfp_pkg::t_desc           o_desc,
    input  logic                     i_q_full,
    input  cfp_pkg::t_bank_free      i_free
);
    import cfp_pkg::*;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_CMD     = 8'b0000_0010,
        PH_LEN_LO  = 8'b0000_0100,
        PH_LEN_HI  = 8'b0000_1000,
        PH_PAYLOAD = 8'b0001_0000,
        PH_CRC_LO  = 8'b0010_0000,
        PH_CRC_HI  = 8'b0100_0000,
        PH_TAIL    = 8'b1000_0000
    } t_phase;

    localparam logic [15:0] CAP16 = 16'(PAYLOAD_CAPACITY);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_fcrc, n_fcrc;
    logic [1:0]  r_busy, n_busy;
    logic        r_bank, n_bank;

    logic        accept;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic        frame_ok;
    logic        fits;

    // Hold the command byte while its bank drains; hold the tail while the queue is full.
    assign o_full = ((r_phase == PH_CMD) && r_busy[r_bank]) ||
                    ((r_phase == PH_TAIL) && i_q_full);
    assign accept = i_push && !o_full;

    assign len_full = {i_data_byte, r_len[7:0]};
    assign cnt_inc  = r_cnt + 16'd1;
    assign frame_ok = (i_data_byte == i_tail_byte) && (r_fcrc == r_crc);
    assign fits     = (r_len <= CAP16);

    assign o_wr_idx = r_cnt[IDX_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_crc       = r_crc;
        n_cnt       = r_cnt;
        n_fcrc      = r_fcrc;
        n_bank      = r_bank;
        n_busy      = r_busy;
        o_wr.en     = 1'b0;
        o_wr.bank   = r_bank;
        o_wr.data   = i_data_byte;
        o_desc_push = 1'b0;
        o_desc.cmd         = r_cmd;
        o_desc.len         = r_len;
        o_desc.fits        = fits;
        o_desc.has_payload = fits && (r_len != 16'd0);
        o_desc.bank        = r_bank;

        if (i_free.valid) begin
            n_busy[i_free.bank] = 1'b0;
        end

        if (accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_data_byte == i_head_byte) begin
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_data_byte;
                    n_crc   = crc_arc_byte(16'h0000, i_data_byte);
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_data_byte};
                    n_crc   = crc_arc_byte(r_crc, i_data_byte);
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = len_full;
                    n_crc   = crc_arc_byte(r_crc, i_data_byte);
                    n_cnt   = 16'd0;
                    n_phase = (len_full != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
                end
                PH_PAYLOAD: begin
                    // Count bytes past capacity, but drop them from the store.
                    o_wr.en = (r_cnt < CAP16);
                    n_crc   = crc_arc_byte(r_crc, i_data_byte);
                    n_cnt   = cnt_inc;
                    if (cnt_inc == r_len) begin
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    n_fcrc  = {8'h00, i_data_byte};
                    n_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    n_fcrc  = {i_data_byte, r_fcrc[7:0]};
                    n_phase = PH_TAIL;
                end
                PH_TAIL: begin
                    n_phase = PH_HUNT;
                    if (frame_ok) begin
                        o_desc_push = 1'b1;
                        if (o_desc.has_payload) begin
                            n_busy[r_bank] = 1'b1;
                            n_bank         = !r_bank;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_cnt   <= '0;
            r_fcrc  <= '0;
            r_busy  <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_cnt   <= n_cnt;
            r_fcrc  <= n_fcrc;
            r_busy  <= n_busy;
            r_bank  <= n_bank;
        end
    end

endmodule

[rtl/cfp_queue.sv]
// Two-entry frame descriptor queue between parser and result stage.
// Depends on cfp_pkg.
module cfp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfp_pkg::t_desc  i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output cfp_pkg::t_desc  o_desc,
    output logic            o_valid
);
    import cfp_pkg::*;

    t_desc      r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_desc  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (i_pop) begin
            n_rp = !r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

[rtl/cfp_back.sv]
// Result stage: two-bank payload store and the result output register.
// Depends on cfp_pkg.
module cfp_back #(
    parameter int unsigned PAYLOAD_CAPACITY = 64,
    localparam int unsigned IDX_W  = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1,
    localparam int unsigned DEPTH  = 2 * PAYLOAD_CAPACITY,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfp_pkg::t_wr         i_wr,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  logic                 i_desc_valid,
    input  cfp_pkg::t_desc       i_desc,
    output logic                 o_desc_pop,
    output cfp_pkg::t_bank_free  o_free,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [7:0]           o_command_code,
    output logic [15:0]          o_declared_length,
    output logic                 o_payload_fits,
    output logic [7:0]           o_payload_byte,
    output logic                 o_byte_present,
    output logic                 o_last_of_frame
);
    import cfp_pkg::*;

    localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(PAYLOAD_CAPACITY);

    logic [7:0]       r_store [DEPTH];
    logic [7:0]       r_rd_data;

    t_desc            r_desc;
    logic             r_active, n_active;
    logic [IDX_W-1:0] r_k, n_k;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_cmd;
    logic [15:0]      r_out_len;
    logic             r_out_fits;
    logic             r_out_present;
    logic             r_out_last;

    logic              issue;
    logic              is_last;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_addr = i_wr.bank ? (BANK_BASE + ADDR_W'(i_wr_idx)) : ADDR_W'(i_wr_idx);
    assign rd_addr = r_desc.bank ? (BANK_BASE + ADDR_W'(r_k)) : ADDR_W'(r_k);

    assign o_desc_pop = !r_active && i_desc_valid;
    assign issue      = r_active && (!r_out_valid || i_pop);
    assign is_last    = !r_desc.has_payload || ((16'(r_k) + 16'd1) == r_desc.len);

    // Release the bank once its final byte has been read out.
    assign o_free.valid = issue && r_desc.has_payload && is_last;
    assign o_free.bank  = r_desc.bank;

    always_comb begin
        n_active    = r_active;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        if (o_desc_pop) begin
            n_active = 1'b1;
            n_k      = '0;
        end
        if (issue) begin
            n_out_valid = 1'b1;
            n_k         = r_k + IDX_W'(1);
            if (is_last) begin
                n_active = 1'b0;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_pop) begin
            r_desc <= i_desc;
        end
        if (issue) begin
            r_out_cmd     <= r_desc.cmd;
            r_out_len     <= r_desc.len;
            r_out_fits    <= r_desc.fits;
            r_out_present <= r_desc.has_payload;
            r_out_last    <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[wr_addr] <= i_wr.data;
        end
        if (issue && r_desc.has_payload) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_command_code    = r_out_cmd;
    assign o_declared_length = r_out_len;
    assign o_payload_fits    = r_out_fits;
    assign o_payload_byte    = r_out_present ? r_rd_data : 8'h00;
    assign o_byte_present    = r_out_present;
    assign o_last_of_frame   = r_out_last;

endmodule

[rtl/command_frame_parser_crc16.sv]
// Top level of the command frame parser with CRC-16/ARC check.
// Depends on cfp_pkg, cfp_front, cfp_queue and cfp_back.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------------
//  bytes in  push / full                  i_data_byte
//  results   empty / pop                  o_command_code, o_declared_length,
//                                         o_payload_fits, o_payload_byte,
//                                         o_byte_present, o_last_of_frame
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// The parser takes one byte per cycle; the CRC update of a byte is done in that cycle.
// Results leave one per cycle while pop is held; between frames the result stage first
// loads each accepted frame's descriptor from the two-entry frame queue.
// full rises on the command byte while the payload bank it would use is still draining,
// and on the tail byte while the frame queue is full; otherwise bytes never stall.
// Reset (synchronous, active low) returns to hunting and empties the queue, no store clear.
module command_frame_parser_crc16 #(
    parameter int unsigned PAYLOAD_CAPACITY = 64,
    localparam int unsigned IDX_W = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic [7:0]  i_data_byte,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_command_code,
    output logic [15:0] o_declared_length,
    output logic        o_payload_fits,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_present,
    output logic        o_last_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import cfp_pkg::*;

    logic [7:0]       r_head_byte;
    logic [7:0]       r_tail_byte;

    t_wr              wr;
    logic [IDX_W-1:0] wr_idx;
    logic             desc_push;
    t_desc            desc_in;
    logic             q_full;
    logic             q_valid;
    t_desc            desc_out;
    logic             desc_pop;
    t_bank_free       bank_free;

    // Always take configuration requests; indexes past the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte <= HEAD_RESET;
            r_tail_byte <= TAIL_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_HEAD_IDX) begin
                r_head_byte <= i_cfg_data;
            end else if (i_cfg_index == CFG_TAIL_IDX) begin
                r_tail_byte <= i_cfg_data;
            end
        end
    end

    // Front: phase machine and CRC, writes payload into the free bank.
    cfp_front #(
        .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .i_head_byte (r_head_byte),
        .i_tail_byte (r_tail_byte),
        .o_wr        (wr),
        .o_wr_idx    (wr_idx),
        .o_desc_push (desc_push),
        .o_desc      (desc_in),
        .i_q_full    (q_full),
        .i_free      (bank_free)
    );

    // Frame queue: decouples the byte stream from the result drain.
    cfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .o_full  (q_full),
        .i_pop   (desc_pop),
        .o_desc  (desc_out),
        .o_valid (q_valid)
    );

    // Back: walks each accepted frame and presents one result per request.
    cfp_back #(
        .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr              (wr),
        .i_wr_idx          (wr_idx),
        .i_desc_valid      (q_valid),
        .i_desc            (desc_out),
        .o_desc_pop        (desc_pop),
        .o_free            (bank_free),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_command_code    (o_command_code),
        .o_declared_length (o_declared_length),
        .o_payload_fits    (o_payload_fits),
        .o_payload_byte    (o_payload_byte),
        .o_byte_present    (o_byte_present),
        .o_last_of_frame   (o_last_of_frame)
    );

endmodule

[rtl/cfp_checker.sv]
// Port-level checks for the command frame parser, bound to the top level.
// Depends on command_frame_parser_crc16 port names and its PAYLOAD_CAPACITY parameter only.
module cfp_checker #(
    parameter int unsigned PAYLOAD_CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_command_code,
    input logic [15:0] o_declared_length,
    input logic        o_payload_fits,
    input logic [7:0]  o_payload_byte,
    input logic        o_byte_present,
    input logic        o_last_of_frame
);

    // Reset drains every pending result.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results pending after reset");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_command_code) &&
                              $stable(o_payload_byte) && $stable(o_last_of_frame)))
        else $error("stalled result changed");

    // A header-only result closes its run and carries no byte.
    a_header_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_present) |-> (o_last_of_frame && (o_payload_byte == 8'h00)))
        else $error("header-only result malformed");

    // Payload bytes appear only for a nonzero length that fits the store.
    a_byte_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_present) |-> (o_payload_fits && (o_declared_length != 16'd0) &&
                                        (o_declared_length <= 16'(PAYLOAD_CAPACITY))))
        else $error("payload byte for a frame that does not fit");

    // Within a run the header fields stay the same from byte to byte.
    a_run_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_frame) |=>
            (!empty && $stable(o_command_code) && $stable(o_declared_length)))
        else $error("run header changed mid-frame");

endmodule

bind command_frame_parser_crc16 cfp_checker #(
    .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
) u_cfp_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for command_frame_parser_crc16: builds framed byte streams,
// predicts the result runs internally and checks them. Depends on cfp_pkg and the RTL.
module tb;
    import cfp_pkg::*;

    // Payload store size of the block under test (default parameter).
    localparam int unsigned CAPACITY = 64;
    localparam int unsigned STORE_IDX_W = $clog2(CAPACITY);
    // Reflected CRC-16/ARC polynomial, kept local to the bench's own CRC.
    localparam logic [15:0] ARC_POLY = 16'hA001;
    // Quiet cycles after the last expected result before touching registers.
    localparam int unsigned DRAIN_CYCLES = 32;
    // Cycles without any accepted request before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 4000;
    // Length of the long receiver hold-off that forces the block to fill.
    localparam int unsigned HOLD_CYCLES = 500;
    // Frame bytes offered by the random part.
    localparam int unsigned RANDOM_BYTES = 24;

    typedef enum logic [2:0] {
        PH_HUNT, PH_CMD, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI, PH_TAIL
    } t_parse_phase;

    typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_TAIL} t_frame_fault;

    typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_SPARSE, RX_SQUARE} t_rx_pattern;

    // One result item as it appears on the output ports.
    typedef struct packed {
        logic [7:0]  cmd;
        logic [15:0] len;
        logic        fits;
        logic [7:0]  pbyte;
        logic        present;
        logic        last;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        pop = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_index = 8'h00;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        full;
    logic        empty;
    logic        o_cfg_ready;
    logic [7:0]  o_command_code;
    logic [15:0] o_declared_length;
    logic        o_payload_fits;
    logic [7:0]  o_payload_byte;
    logic        o_byte_present;
    logic        o_last_of_frame;

    command_frame_parser_crc16 u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .i_data_byte       (i_data_byte),
        .full              (full),
        .empty             (empty),
        .pop               (pop),
        .o_command_code    (o_command_code),
        .o_declared_length (o_declared_length),
        .o_payload_fits    (o_payload_fits),
        .o_payload_byte    (o_payload_byte),
        .o_byte_present    (o_byte_present),
        .o_last_of_frame   (o_last_of_frame),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Parser mirror: framing registers, parse state and payload store.
    // ------------------------------------------------------------------
    logic [7:0]   m_head;
    logic [7:0]   m_tail;
    t_parse_phase m_phase;
    logic [7:0]   m_cmd;
    logic [15:0]  m_len;
    logic [15:0]  m_crc;
    logic [15:0]  m_count;
    logic [15:0]  m_frame_crc;
    logic [7:0]   m_store [CAPACITY];

    // Result items still owed by the block, oldest first.
    t_frame_result pending_results[$];

    int          mismatch_count = 0;
    int          burst_left = 0;
    bit          tx_steady = 1'b0;
    logic        rx_hold = 1'b0;
    t_rx_pattern rx_mode = RX_FLOW;
    logic [15:0] rx_cycle = 16'h0000;
    int unsigned idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bitwise form of CRC-16/ARC: shift right, fold the polynomial when the
    // bit falling out differs from the data bit.
    function automatic logic [15:0] crc16_arc_update(input logic [15:0] acc,
                                                     input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ d[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ ARC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void reset_parser_model();
        m_head      = HEAD_RESET;
        m_tail      = TAIL_RESET;
        m_phase     = PH_HUNT;
        m_cmd       = 8'h00;
        m_len       = 16'h0000;
        m_crc       = 16'h0000;
        m_count     = 16'h0000;
        m_frame_crc = 16'h0000;
        for (int i = 0; i < CAPACITY; i++) begin
            m_store[STORE_IDX_W'(i)] = 8'h00;
        end
    endfunction

    // Advance the mirror by one accepted byte and queue any results it releases.
    function automatic void track_byte(input logic [7:0] b);
        t_frame_result r;
        logic          fits;
        int            k;
        case (m_phase)
            PH_HUNT: begin
                if (b == m_head) begin
                    m_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                m_cmd   = b;
                m_crc   = crc16_arc_update(16'h0000, b);
                m_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                m_len   = {8'h00, b};
                m_crc   = crc16_arc_update(m_crc, b);
                m_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                m_len[15:8] = b;
                m_crc       = crc16_arc_update(m_crc, b);
                m_count     = 16'h0000;
                // A zero length goes straight to the CRC bytes.
                if (m_len != 16'h0000) begin
                    m_phase = PH_PAYLOAD;
                end else begin
                    m_phase = PH_CRC_LO;
                end
            end
            PH_PAYLOAD: begin
                // Bytes past the store are counted and checked, not kept.
                if (m_count < CAPACITY) begin
                    m_store[STORE_IDX_W'(m_count)] = b;
                end
                m_crc   = crc16_arc_update(m_crc, b);
                m_count = m_count + 16'd1;
                if (m_count == m_len) begin
                    m_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                m_frame_crc = {8'h00, b};
                m_phase     = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                m_frame_crc[15:8] = b;
                m_phase           = PH_TAIL;
            end
            PH_TAIL: begin
                m_phase = PH_HUNT;
                // Drop the frame silently on a bad tail or CRC.
                if (b == m_tail && m_frame_crc == m_crc) begin
                    fits = (m_len <= CAPACITY);
                    r.cmd = m_cmd;
                    r.len = m_len;
                    r.fits = fits;
                    if (fits && m_len != 16'h0000) begin
                        for (k = 0; k < int'(m_len); k++) begin
                            r.pbyte   = m_store[STORE_IDX_W'(k)];
                            r.present = 1'b1;
                            r.last    = (k == int'(m_len) - 1);
                            pending_results.push_back(r);
                        end
                    end else begin
                        // Header-only result for empty or oversized payloads.
                        r.pbyte   = 8'h00;
                        r.present = 1'b0;
                        r.last    = 1'b1;
                        pending_results.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one byte request and hold it until the block takes it. Bursts of
    // random length are separated by random gaps unless tx_steady is set.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            if (!tx_steady) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        push        <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        track_byte(b);
    endtask

    // Send a whole frame. fill < 0 gives random payload with head bytes mixed in.
    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                              input t_frame_fault fault, input int fill);
        logic [15:0] acc;
        logic [15:0] crc_sent;
        logic [7:0]  tail_sent;
        logic [7:0]  d;
        send_byte(m_head);
        acc = crc16_arc_update(16'h0000, cmd);
        send_byte(cmd);
        acc = crc16_arc_update(acc, len[7:0]);
        send_byte(len[7:0]);
        acc = crc16_arc_update(acc, len[15:8]);
        send_byte(len[15:8]);
        for (int i = 0; i < int'(len); i++) begin
            if (fill >= 0) begin
                d = fill[7:0];
            end else if ($urandom_range(0, 7) == 0) begin
                d = m_head;
            end else begin
                d = 8'($urandom_range(0, 255));
            end
            acc = crc16_arc_update(acc, d);
            send_byte(d);
        end
        crc_sent  = acc;
        tail_sent = m_tail;
        if (fault == FRAME_BAD_CRC) begin
            crc_sent = crc_sent ^ (16'h0001 << $urandom_range(0, 15));
        end
        if (fault == FRAME_BAD_TAIL) begin
            tail_sent = tail_sent ^ 8'($urandom_range(1, 255));
        end
        send_byte(crc_sent[7:0]);
        send_byte(crc_sent[15:8]);
        send_byte(tail_sent);
    endtask

    // Line noise between frames; never the head byte, so the parser keeps hunting.
    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == m_head) begin
                b = b ^ 8'h01;
            end
            send_byte(b);
        end
    endtask

    // Drop push, wait for every owed result, then let the block go quiet.
    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write head and tail back to back; valid stays high across both requests.
    task automatic set_framing(input logic [7:0] head, input logic [7:0] tail);
        settle();
        for (int n = 0; n < 2; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (n == 0) ? CFG_HEAD_IDX : CFG_TAIL_IDX;
            i_cfg_data  <= (n == 0) ? head : tail;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (n == 0) begin
                m_head = head;
            end else begin
                m_tail = tail;
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: check each accepted result, then choose the next pop.
    // ------------------------------------------------------------------
    function automatic void flag_mismatch(input string why, input t_frame_result want,
                                          input t_frame_result got);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
            $display("%0t mismatch (%s): expected cmd=%02h len=%04h fits=%0d byte=%02h",
                     $realtime, why, want.cmd, want.len, want.fits, want.pbyte,
                     " present=%0d last=%0d", want.present, want.last);
            $display("    got cmd=%02h len=%04h fits=%0d byte=%02h present=%0d last=%0d",
                     got.cmd, got.len, got.fits, got.pbyte, got.present, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && pop && !empty) begin
            got = {o_command_code, o_declared_length, o_payload_fits,
                   o_payload_byte, o_byte_present, o_last_of_frame};
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    flag_mismatch("wrong field", want, got);
                end
            end
        end
        // Pick a new random stall pattern each time rx_cycle[5:0] wraps to zero.
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[5:0] == 6'd0) begin
            rx_mode <= t_rx_pattern'($urandom_range(0, 3));
        end
        if (!i_rst_n || rx_hold) begin
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FLOW:   pop <= 1'b1;
                RX_COIN:   pop <= 1'($urandom_range(0, 1));
                RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                RX_SQUARE: pop <= rx_cycle[3];
            endcase
        end
    end

    // Watchdog: count cycles in which no request of any channel is accepted.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Confirm the bench's own CRC against the standard check value.
    task automatic test_crc_check_value();
        string       s;
        logic [15:0] acc;
        s   = "123456789";
        acc = 16'h0000;
        for (int i = 0; i < s.len(); i++) begin
            acc = crc16_arc_update(acc, s[i]);
        end
        if (acc !== 16'hBB3D) begin
            mismatch_count = mismatch_count + 1;
            $display("bench CRC check value wrong: %04h", acc);
        end
    endtask

    // Directed frames with the reset framing bytes.
    task automatic test_frame_cases();
        send_frame(8'h00, 16'd1, FRAME_GOOD, 8'h00);        // shortest payload, all zero
        send_frame(8'hFF, 16'd64, FRAME_GOOD, 8'hFF);       // exactly fills the store
        send_frame(8'h11, 16'd0, FRAME_GOOD, -1);           // zero length
        send_frame(8'h22, 16'd65, FRAME_GOOD, -1);          // one past the store
        send_frame(m_head, 16'd5, FRAME_GOOD, int'(m_head)); // head bytes inside a frame
        send_frame(8'h33, 16'd4, FRAME_BAD_CRC, -1);
        send_frame(8'h44, 16'd4, FRAME_BAD_TAIL, -1);
        send_frame(8'h55, 16'd0, FRAME_BAD_TAIL, -1);
        send_noise(6);
        send_frame(8'h66, 16'd3, FRAME_GOOD, -1);
        send_frame(8'h77, 16'd2, FRAME_GOOD, -1);           // back to back
        settle();
    endtask

    // Walk the framing registers through their extremes and back to reset.
    task automatic test_register_settings();
        logic [7:0] heads [5];
        logic [7:0] tails [5];
        heads = '{8'h00, 8'hFF, 8'h3C, 8'h00, HEAD_RESET};
        tails = '{8'hFF, 8'h00, 8'h3C, 8'h00, TAIL_RESET};
        for (int s = 0; s < 5; s++) begin
            set_framing(heads[3'(s)], tails[3'(s)]);
            send_frame(8'($urandom_range(0, 255)), 16'd2, FRAME_GOOD, -1);
            send_frame(8'($urandom_range(0, 255)), 16'd0, FRAME_GOOD, -1);
            send_noise(2);
            send_frame(8'($urandom_range(0, 255)), 16'd1, FRAME_BAD_TAIL, -1);
        end
        settle();
    endtask

    // Hold the receiver off while the sender streams frames, so the block fills.
    task automatic test_backpressure();
        settle();
        tx_steady = 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int f = 0; f < 4; f++) begin
            send_frame(8'($urandom_range(0, 255)), 16'd6, FRAME_GOOD, -1);
        end
        tx_steady = 1'b0;
        settle();
    endtask

    // Mostly well-formed frames with random content and small sizes, the rest
    // broken frames and noise, over several random framing settings.
    task automatic test_random_traffic();
        int          sent;
        int          pick;
        logic [15:0] len;
        for (int phase = 0; phase < 4; phase++) begin
            set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            sent = 0;
            while (sent < int'(RANDOM_BYTES / 4)) begin
                tx_steady = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 86) begin
                    len = 16'($urandom_range(0, 8));
                end else if (pick < 96) begin
                    len = 16'($urandom_range(9, 64));
                end else begin
                    len = 16'($urandom_range(65, 80));
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame(8'($urandom_range(0, 255)), len, FRAME_GOOD, -1);
                    sent = sent + int'(len) + 6;
                end else if (pick < 82) begin
                    send_frame(8'($urandom_range(0, 255)), len, FRAME_BAD_CRC, -1);
                    sent = sent + int'(len) + 6;
                end else if (pick < 94) begin
                    send_frame(8'($urandom_range(0, 255)), len, FRAME_BAD_TAIL, -1);
                    sent = sent + int'(len) + 6;
                end else begin
                    send_noise($urandom_range(1, 6));
                end
            end
            tx_steady = 1'b0;
        end
    endtask

    initial begin
        reset_parser_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_crc_check_value();
        test_frame_cases();
        test_register_settings();
        test_backpressure();
        test_random_traffic();

        settle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
